/* sv/lzssd_pkg.sv */
package lzssd_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int ADDR_W      = $clog2(WINDOW_SIZE);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int DIST_W      = 13;
   localparam int LEN_W       = 5;
   localparam int FLAG_IDX_W  = 4;

   localparam logic [LEN_W-1:0]  MIN_MATCH = LEN_W'(3);
   localparam logic [7:0]        FLAG_MSB  = 8'h80;
   localparam logic [FLAG_IDX_W-1:0] FLAG_DONE = FLAG_IDX_W'(8);

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FAR   = 2'd1,
      STATUS_TRUNC = 2'd2
   } status_type;

endpackage

/* sv/lzss_stream_decompressor.sv */
// a literal result is presented the cycle after its byte is accepted; for a match, the second
// byte starts the history ram read and the copy state, and each copied byte then waits for a free output slot
// flag, literal and first match bytes are accepted whenever the output slot is free; a match's second
// byte holds the input until its copy ends, one history ram read per copied byte
// reset: synchronous, active high; clears control state only, the history ram is not cleared
module lzss_stream_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic [1:0] rsp_status
);

   localparam int AW = lzssd_pkg::ADDR_W;
   localparam int CW = lzssd_pkg::COUNT_W;
   localparam int LW = lzssd_pkg::LEN_W;
   localparam int FW = lzssd_pkg::FLAG_IDX_W;

   typedef enum logic {
      S_IDLE,
      S_COPY
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          write_pos_ff, write_pos_in;
   logic [CW-1:0]          produced_ff, produced_in;
   logic [7:0]             flag_bits_ff, flag_bits_in;
   logic [FW-1:0]          flag_index_ff, flag_index_in;
   logic                   phase_ff, phase_in;
   logic [7:0]             pending_high_ff, pending_high_in;
   logic [LW-1:0]          len_left_ff, len_left_in;
   logic [AW-1:0]          src_ff, src_in;
   logic                   dist_one_ff, dist_one_in;
   logic                   first_ff, first_in;
   logic [7:0]             last_byte_ff, last_byte_in;
   logic                   end_pending_ff, end_pending_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_out_byte_ff, rsp_out_byte_in;
   logic                   rsp_run_last_ff, rsp_run_last_in;
   lzssd_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                   slot_free;
   logic                   accept;
   logic                   do_clear;
   logic [lzssd_pkg::DIST_W-1:0] match_dist;
   logic [LW-1:0]          match_len;
   logic [AW-1:0]          src_calc;
   logic [7:0]             copy_byte;
   logic                   is_literal;

   logic                   ram_wr_en;
   logic [7:0]             ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [7:0]             ram_rd_data;

   lzssd_hist_ram #(
      .WIDTH (8),
      .DEPTH (lzssd_pkg::WINDOW_SIZE)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_pos_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign match_dist = {1'b0, pending_high_ff[3:0], req_in_byte} + lzssd_pkg::DIST_W'(1);
   assign match_len  = {1'b0, pending_high_ff[7:4]} + lzssd_pkg::MIN_MATCH;
   assign src_calc   = write_pos_ff - AW'(match_dist);
   assign is_literal = (flag_bits_ff & (lzssd_pkg::FLAG_MSB >> flag_index_ff[2:0])) != 8'd0;
   // distance one repeats the byte just written, which the ram cannot return yet
   assign copy_byte  = (dist_one_ff && !first_ff) ? last_byte_ff : ram_rd_data;

   always_comb begin
      state_in        = state_ff;
      write_pos_in    = write_pos_ff;
      produced_in     = produced_ff;
      flag_bits_in    = flag_bits_ff;
      flag_index_in   = flag_index_ff;
      phase_in        = phase_ff;
      pending_high_in = pending_high_ff;
      len_left_in     = len_left_ff;
      src_in          = src_ff;
      dist_one_in     = dist_one_ff;
      first_in        = first_ff;
      last_byte_in    = last_byte_ff;
      end_pending_in  = end_pending_ff;
      rsp_valid_in    = slot_free ? 1'b0 : rsp_valid_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_status_in   = rsp_status_ff;
      ram_wr_en       = 1'b0;
      ram_wr_data     = req_in_byte;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = src_ff;
      do_clear        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (phase_ff) begin
                  phase_in      = 1'b0;
                  flag_index_in = flag_index_ff + FW'(1);
                  if (CW'(match_dist) > produced_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_out_byte_in = 8'd0;
                     rsp_run_last_in = 1'b1;
                     rsp_status_in   = lzssd_pkg::STATUS_FAR;
                     do_clear        = req_stream_end;
                  end else begin
                     ram_rd_en      = 1'b1;
                     ram_rd_addr    = src_calc;
                     src_in         = src_calc;
                     len_left_in    = match_len;
                     dist_one_in    = (match_dist == lzssd_pkg::DIST_W'(1));
                     first_in       = 1'b1;
                     end_pending_in = req_stream_end;
                     state_in       = S_COPY;
                  end
               end else if (flag_index_ff >= lzssd_pkg::FLAG_DONE) begin
                  flag_bits_in  = req_in_byte;
                  flag_index_in = '0;
                  do_clear      = req_stream_end;
               end else if (is_literal) begin
                  ram_wr_en       = 1'b1;
                  write_pos_in    = write_pos_ff + AW'(1);
                  if (produced_ff < CW'(lzssd_pkg::WINDOW_SIZE)) begin
                     produced_in = produced_ff + CW'(1);
                  end
                  flag_index_in   = flag_index_ff + FW'(1);
                  rsp_valid_in    = 1'b1;
                  rsp_out_byte_in = req_in_byte;
                  rsp_run_last_in = 1'b1;
                  rsp_status_in   = lzssd_pkg::STATUS_OK;
                  do_clear        = req_stream_end;
               end else begin
                  pending_high_in = req_in_byte;
                  phase_in        = 1'b1;
                  if (req_stream_end) begin
                     // stream stops between the two bytes of a match
                     rsp_valid_in    = 1'b1;
                     rsp_out_byte_in = 8'd0;
                     rsp_run_last_in = 1'b1;
                     rsp_status_in   = lzssd_pkg::STATUS_TRUNC;
                     do_clear        = 1'b1;
                  end
               end
            end
         end
         S_COPY: begin
            if (slot_free) begin
               ram_wr_en       = 1'b1;
               ram_wr_data     = copy_byte;
               write_pos_in    = write_pos_ff + AW'(1);
               if (produced_ff < CW'(lzssd_pkg::WINDOW_SIZE)) begin
                  produced_in = produced_ff + CW'(1);
               end
               last_byte_in    = copy_byte;
               first_in        = 1'b0;
               rsp_valid_in    = 1'b1;
               rsp_out_byte_in = copy_byte;
               rsp_run_last_in = (len_left_ff == LW'(1));
               rsp_status_in   = lzssd_pkg::STATUS_OK;
               if (len_left_ff != LW'(1)) begin
                  len_left_in = len_left_ff - LW'(1);
                  src_in      = src_ff + AW'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = src_ff + AW'(1);
               end else begin
                  state_in = S_IDLE;
                  do_clear = end_pending_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_clear) begin
         write_pos_in    = '0;
         produced_in     = '0;
         flag_bits_in    = '0;
         flag_index_in   = lzssd_pkg::FLAG_DONE;
         phase_in        = 1'b0;
         pending_high_in = '0;
         end_pending_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         write_pos_ff    <= '0;
         produced_ff     <= '0;
         flag_bits_ff    <= '0;
         flag_index_ff   <= lzssd_pkg::FLAG_DONE;
         phase_ff        <= 1'b0;
         pending_high_ff <= '0;
         len_left_ff     <= '0;
         end_pending_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_pos_ff    <= write_pos_in;
         produced_ff     <= produced_in;
         flag_bits_ff    <= flag_bits_in;
         flag_index_ff   <= flag_index_in;
         phase_ff        <= phase_in;
         pending_high_ff <= pending_high_in;
         len_left_ff     <= len_left_in;
         end_pending_ff  <= end_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      src_ff          <= src_in;
      dist_one_ff     <= dist_one_in;
      first_ff        <= first_in;
      last_byte_ff    <= last_byte_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_run_last = rsp_run_last_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_produced_bound: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= CW'(lzssd_pkg::WINDOW_SIZE))
      else $error("produced count beyond window");

   a_write_has_result: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> rsp_valid_ff)
      else $error("history written without a result transaction");

   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> len_left_ff != '0)
      else $error("copy running with no bytes left");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lzssd_pkg::STATUS_OK |-> rsp_run_last && rsp_out_byte == 8'd0)
      else $error("error result not single or not zero");
`endif

endmodule

/* sv/lzssd_hist_ram.sv */
module lzssd_hist_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/tb_lzss_stream_decompressor.sv */
`timescale 1ns / 1ps

module tb_lzss_stream_decompressor;

   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic [7:0]            data;
      logic                  last;
      lzssd_pkg::status_type status;
   } decoded_type;

   typedef enum int {END_CLEAN, END_IN_MATCH, END_ON_FLAG} stream_close_type;

   // keeps its own copy of the decoder state and the queue of bytes the block still owes
   class lzss_output_ledger;
      logic [7:0]                       window [lzssd_pkg::WINDOW_SIZE];
      logic [lzssd_pkg::ADDR_W-1:0]     wr_ptr;
      logic [lzssd_pkg::COUNT_W-1:0]    made;
      logic [7:0]                       flags;
      logic [lzssd_pkg::FLAG_IDX_W-1:0] tok_idx;
      logic                             want_second;
      logic [7:0]                       match_hi;
      decoded_type                      pending_bytes[$];
      int                               mismatches;
      int                               checked;
      int                               far_seen;
      int                               trunc_seen;

      function new();
         restart();
         mismatches = 0;
         checked    = 0;
         far_seen   = 0;
         trunc_seen = 0;
      endfunction

      function void restart();
         wr_ptr      = '0;
         made        = '0;
         flags       = '0;
         tok_idx     = lzssd_pkg::FLAG_DONE;
         want_second = 1'b0;
         match_hi    = '0;
      endfunction

      function void keep(logic [7:0] v);
         window[wr_ptr] = v;
         wr_ptr = wr_ptr + 1'b1;
         if (made < lzssd_pkg::WINDOW_SIZE) made = made + 1'b1;
      endfunction

      function void owe(logic [7:0] v, lzssd_pkg::status_type st);
         decoded_type d;
         d.data   = v;
         d.last   = 1'b0;
         d.status = st;
         pending_bytes = {pending_bytes, d};
      endfunction

      function void take_code_byte(logic [7:0] b, logic fin);
         int                           run_start;
         int                           span;
         int                           back_dist;
         logic [lzssd_pkg::ADDR_W-1:0] src;
         decoded_type                  tail;
         run_start = pending_bytes.size();
         if (want_second) begin
            span = int'(match_hi[7:4]) + int'(lzssd_pkg::MIN_MATCH);
            back_dist = {match_hi[3:0], b} + 1;
            want_second = 1'b0;
            tok_idx = tok_idx + 1'b1;
            if (back_dist > made) begin
               owe(8'h00, lzssd_pkg::STATUS_FAR);
            end else begin
               // byte by byte so an overlapping copy sees its own output
               for (int i = 0; i < span; i++) begin
                  src = wr_ptr - lzssd_pkg::ADDR_W'(back_dist);
                  owe(window[src], lzssd_pkg::STATUS_OK);
                  keep(window[src]);
               end
            end
         end else if (tok_idx >= lzssd_pkg::FLAG_DONE) begin
            flags   = b;
            tok_idx = '0;
         end else if ((flags & (lzssd_pkg::FLAG_MSB >> tok_idx)) != 8'h00) begin
            keep(b);
            owe(b, lzssd_pkg::STATUS_OK);
            tok_idx = tok_idx + 1'b1;
         end else begin
            match_hi    = b;
            want_second = 1'b1;
         end
         if (fin) begin
            if (want_second) owe(8'h00, lzssd_pkg::STATUS_TRUNC);
            restart();
         end
         if (pending_bytes.size() > run_start) begin
            tail = pending_bytes[pending_bytes.size() - 1];
            tail.last = 1'b1;
            pending_bytes[pending_bytes.size() - 1] = tail;
         end
      endfunction

      function void complain(string what, decoded_type want, decoded_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s: expected byte %02h last %b status %0d, %s %02h last %b status %0d",
                     $realtime, what, want.data, want.last, want.status,
                     "got byte", got.data, got.last, got.status);
      endfunction

      function void match_output(logic [7:0] data, logic last, logic [1:0] st);
         decoded_type got;
         decoded_type want;
         got.data   = data;
         got.last   = last;
         got.status = lzssd_pkg::status_type'(st);
         if (pending_bytes.size() == 0) begin
            complain("unexpected result", '0, got);
         end else begin
            want = pending_bytes.pop_front();
            checked++;
            if (want.status == lzssd_pkg::STATUS_FAR) far_seen++;
            if (want.status == lzssd_pkg::STATUS_TRUNC) trunc_seen++;
            if (got.data !== want.data || got.last !== want.last || got.status !== want.status)
               complain("result mismatch", want, got);
         end
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic [1:0] rsp_status;

   lzss_output_ledger ledger = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;
   int          codes_sent    = 0;
   int          streams_sent  = 0;

   lzss_stream_decompressor DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_status     (rsp_status)
   );

   always #2 clock = ~clock;

   // input is noted before the result check, both sampled at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) ledger.take_code_byte(req_in_byte, req_stream_end);
         if (rsp_valid && rsp_ready) ledger.match_output(rsp_out_byte, rsp_run_last, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_code(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_stream_end <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      codes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // well-formed stream with random content; distances mostly inside the produced history
   task automatic send_stream(input int n_tok, input stream_close_type close_kind);
      int         made;
      int         len;
      int         back_dist;
      int         reach;
      logic [7:0] flags;
      logic [11:0] code;
      logic       last;
      logic       cut;
      made = 0;
      flags = 8'h00;
      streams_sent++;
      for (int t = 0; t < n_tok; t++) begin
         last = (t == n_tok - 1);
         cut  = last && close_kind == END_IN_MATCH;
         if (t % 8 == 0) begin
            flags = 8'($urandom);
            if (close_kind == END_IN_MATCH && n_tok - 1 - t < 8)
               flags[7 - (n_tok - 1 - t)] = 1'b0;
            send_code(flags, 1'b0);
         end
         if (flags[7 - t % 8]) begin
            send_code(8'($urandom), last && close_kind == END_CLEAN);
            if (made < lzssd_pkg::WINDOW_SIZE) made++;
         end else begin
            len = $urandom_range(15);
            if (made > 0 && $urandom_range(9) != 0) begin
               reach = ($urandom_range(2) == 0) ? made : ((made < 4) ? made : 4);
               back_dist = $urandom_range(reach, 1);
               made  = (made + len + 3 > lzssd_pkg::WINDOW_SIZE) ?
                       lzssd_pkg::WINDOW_SIZE : made + len + 3;
            end else if (made < lzssd_pkg::WINDOW_SIZE) begin
               back_dist = $urandom_range(lzssd_pkg::WINDOW_SIZE, made + 1);
            end else begin
               back_dist = $urandom_range(lzssd_pkg::WINDOW_SIZE, 1);
            end
            code = 12'(back_dist - 1);
            send_code({len[3:0], code[11:8]}, cut);
            if (!cut) send_code(code[7:0], last && close_kind == END_CLEAN);
         end
      end
      if (close_kind == END_ON_FLAG || n_tok == 0) send_code(8'($urandom), 1'b1);
   endtask

   task automatic send_noise(input int n);
      streams_sent++;
      for (int i = 0; i < n - 1; i++) send_code(8'($urandom), 1'b0);
      send_code(8'($urandom), 1'b1);
   endtask

   task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle, input int count);
      int start;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      start = codes_sent;
      while (codes_sent - start < count) begin
         if ($urandom_range(4) == 0) send_noise($urandom_range(6, 1));
         else send_stream($urandom_range(14), stream_close_type'($urandom_range(2)));
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // flag byte carrying the end marker: nothing comes out
      send_code(8'h00, 1'b1);
      // literals 00/ff, overlapping copy at distance 1 and max length, two matches
      // reaching beyond the history, then a literal that ends the stream
      send_code(8'hc4, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'hff, 1'b0);
      send_code(8'hf0, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'h01, 1'b0);
      send_code(8'h0f, 1'b0);
      send_code(8'hff, 1'b0);
      send_code(8'ha5, 1'b0);
      send_code(8'h12, 1'b1);
      // match with nothing produced yet, then a truncated match
      send_code(8'h00, 1'b0);
      send_code(8'h30, 1'b0);
      send_code(8'h00, 1'b0);
      send_code(8'hff, 1'b1);
      // end right after a literal token
      send_code(8'h80, 1'b0);
      send_code(8'h7e, 1'b1);
      wait_drained();

      // receiver stalls long while the sender keeps pushing streams
      send_idle_pct = 0;
      hold_requests = hold_requests + 1;
      send_stream(12, END_CLEAN);
      send_stream(10, END_CLEAN);
      wait_drained();

      run_phase(11, 55, 14);
      run_phase(55, 11, 14);
      run_phase(0, 0, 14);

      $display("sent %0d compressed bytes in %0d streams, checked %0d decoded results",
               codes_sent, streams_sent, ledger.checked);
      $display("results with far distance: %0d, with truncated match: %0d, mismatches: %0d",
               ledger.far_seen, ledger.trunc_seen, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", ledger.pending());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* lzss_stream_decompressor.f */
sv/lzssd_pkg.sv
sv/lzssd_hist_ram.sv
sv/lzss_stream_decompressor.sv
sim/tb_lzss_stream_decompressor.sv
